### design/rfes_pkg.sv
package rfes_pkg;

	// operation codes of an input beat
	typedef enum logic [1:0] {
		OP_DETECT = 2'd0,
		OP_ARM    = 2'd1,
		OP_DISARM = 2'd2,
		OP_FORCE  = 2'd3
	} op_t;

	// calibration requests
	typedef enum logic [1:0] {
		CAL_NONE      = 2'd0,
		CAL_DISARMED  = 2'd1,
		CAL_STARTUP   = 2'd2,
		CAL_PREFLIGHT = 2'd3
	} cal_t;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 23;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAIN_DEPLOY_ALT = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGING_DELAY   = 1'd1;

	// configuration reset values
	localparam logic [22:0] MAIN_DEPLOY_ALT_RESET = 23'd3000;
	localparam logic [15:0] STAGING_DELAY_RESET   = 16'd1000;

	// sensor thresholds in fixed-point units
	localparam logic signed [15:0] ACC_BURN_MIN = 16'sd252;
	localparam logic signed [24:0] DROP_TRIGGER = 25'sd100;
	localparam logic signed [15:0] FAST_DESCENT = -16'sd600;
	localparam logic signed [23:0] LANDED_ALT   = 24'sd2000;
	localparam logic signed [15:0] LANDED_VEL   = -16'sd20;

	// phase waits in ms
	localparam int WAIT_SHORT    = 100;
	localparam int WAIT_BURN     = 200;
	localparam int WAIT_STARTUP  = 500;
	localparam int WAIT_SS_DROP  = 1000;
	localparam int WAIT_DROGUE   = 2000;
	localparam int WAIT_SS_COAST = 3000;
	localparam int WAIT_MAIN     = 5000;
	localparam int WAIT_LANDING  = 30000;

	// classified item handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] now_ms;
		logic [3:0]  forced_phase;
		logic        burn;
		logic        burnout;
		logic        drop;
		logic        fast;
		logic        landed;
		logic        main_ok;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [3:0] phase;
		logic       is_armed;
		logic       fire_apogee;
		logic       fire_main;
		logic       fire_second_stage;
		logic       in_flight_mark;
		cal_t       calibrate_request;
		logic       bad_phase;
	} result_t;

endpackage

### design/rocket_flight_event_sequencer.sv
// Flight-phase sequencer for a rocket. Each input beat is one operation: a detect
// tick with time and sensor readings, arm, disarm, or force phase. A front stage
// classifies the readings against the fixed thresholds and the main deploy altitude
// and queues the beat; a back stage holds phase, arm flag and phase entry time and
// produces exactly one result beat per input beat, in order, carrying the new phase,
// the pyro pulses, the calibration request and the bad-phase flag. One beat is
// accepted per cycle while full is low; it waits in the classify queue until the
// back step writes its result into the result queue, each queue QUEUE_DEPTH deep.
// The back step, a wrapping TIME_BITS subtract and compares, runs once per cycle
// while an item waits and the result queue has room. Write the configuration
// registers only while no beat is in flight; cfg_ready is always high.
module rocket_flight_event_sequencer #(
	parameter int TIME_BITS   = 32,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rfes_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rfes_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          operation,
	input  logic [31:0]                         now_ms,
	input  logic signed [15:0]                  accel_axis,
	input  logic signed [23:0]                  altitude,
	input  logic signed [23:0]                  peak_altitude,
	input  logic signed [15:0]                  climb_rate,
	input  logic signed [15:0]                  vertical_velocity,
	input  logic [3:0]                          forced_phase,
	input  logic                                pop,
	output logic                                empty,
	output logic [3:0]                          phase,
	output logic                                is_armed,
	output logic                                fire_apogee,
	output logic                                fire_main,
	output logic                                fire_second_stage,
	output logic                                in_flight_mark,
	output logic [1:0]                          calibrate_request,
	output logic                                bad_phase
);
	import rfes_pkg::*;

	item_t       item_in;
	item_t       item_out;
	logic        item_empty;
	logic        item_pop;
	logic [15:0] staging_delay;
	result_t     res_in;
	result_t     res_out;
	logic        res_push;
	logic        res_full;

	assign cfg_ready = 1'b1;

	// classify and hold configuration
	rfes_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operation         (operation),
		.now_ms            (now_ms),
		.accel_axis        (accel_axis),
		.altitude          (altitude),
		.peak_altitude     (peak_altitude),
		.climb_rate        (climb_rate),
		.vertical_velocity (vertical_velocity),
		.forced_phase      (forced_phase),
		.item              (item_in),
		.staging_delay     (staging_delay)
	);

	// queue of classified beats
	rfes_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item_in),
		.full   (full),
		.pop    (item_pop),
		.dout   (item_out),
		.empty  (item_empty)
	);

	// sequencer step
	rfes_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_out),
		.item_empty    (item_empty),
		.item_pop      (item_pop),
		.staging_delay (staging_delay),
		.result        (res_in),
		.result_push   (res_push),
		.result_full   (res_full)
	);

	// result queue
	rfes_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign phase             = res_out.phase;
	assign is_armed          = res_out.is_armed;
	assign fire_apogee       = res_out.fire_apogee;
	assign fire_main         = res_out.fire_main;
	assign fire_second_stage = res_out.fire_second_stage;
	assign in_flight_mark    = res_out.in_flight_mark;
	assign calibrate_request = res_out.calibrate_request;
	assign bad_phase         = res_out.bad_phase;

endmodule

### design/rfes_fifo.sv
module rfes_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/rfes_front.sv
module rfes_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [rfes_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [rfes_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic [1:0]                             operation,
	input  logic [31:0]                            now_ms,
	input  logic signed [15:0]                     accel_axis,
	input  logic signed [23:0]                     altitude,
	input  logic signed [23:0]                     peak_altitude,
	input  logic signed [15:0]                     climb_rate,
	input  logic signed [15:0]                     vertical_velocity,
	input  logic [3:0]                             forced_phase,
	output rfes_pkg::item_t                        item,
	output logic [15:0]                            staging_delay
);
	import rfes_pkg::*;

	logic [22:0]        main_deploy_alt_q;
	logic [15:0]        staging_delay_q;
	logic signed [24:0] alt_drop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_deploy_alt_q <= MAIN_DEPLOY_ALT_RESET;
			staging_delay_q   <= STAGING_DELAY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAIN_DEPLOY_ALT: main_deploy_alt_q <= cfg_data;
				CFG_STAGING_DELAY:   staging_delay_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign staging_delay = staging_delay_q;

	// distance below peak, one bit wider so it cannot overflow
	assign alt_drop = {peak_altitude[23], peak_altitude} - {altitude[23], altitude};

	// sensor classification, independent of sequencer state
	always_comb begin
		item.op           = op_t'(operation);
		item.now_ms       = now_ms;
		item.forced_phase = forced_phase;
		item.burn         = (accel_axis >= ACC_BURN_MIN);
		item.burnout      = accel_axis[15];
		item.drop         = (alt_drop > DROP_TRIGGER);
		item.fast         = (climb_rate < FAST_DESCENT);
		item.landed       = (altitude < LANDED_ALT) && (vertical_velocity > LANDED_VEL);
		item.main_ok      = (altitude <= $signed({1'b0, main_deploy_alt_q}));
	end

endmodule

### design/rfes_back.sv
module rfes_back #(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rfes_pkg::item_t   item,
	input  logic              item_empty,
	output logic              item_pop,
	input  logic [15:0]       staging_delay,
	output rfes_pkg::result_t result,
	output logic              result_push,
	input  logic              result_full
);
	import rfes_pkg::*;

	typedef enum logic [3:0] {
		PH_STARTUP   = 4'd0,
		PH_PREFLIGHT = 4'd1,
		PH_BOOST     = 4'd2,
		PH_SS_DELAY  = 4'd3,
		PH_SS_IGNITE = 4'd4,
		PH_SS_BOOST  = 4'd5,
		PH_COAST     = 4'd6,
		PH_FREE_FALL = 4'd7,
		PH_DROGUE    = 4'd8,
		PH_DROGUE_NG = 4'd9,
		PH_MAIN      = 4'd10,
		PH_RECOV_NG  = 4'd11,
		PH_LANDING   = 4'd12,
		PH_SHUTDOWN  = 4'd13
	} phase_t;

	logic [3:0]           phase_q;
	logic                 armed_q;
	logic                 entry_done_q;
	logic [TIME_BITS-1:0] entry_time_q;

	logic [3:0]           phase_n;
	logic [3:0]           next_phase;
	logic                 armed_n;
	logic                 entry_done_n;
	logic [TIME_BITS-1:0] entry_time_n;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] entry_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 ge_short, ge_burn, ge_startup, ge_ss_drop, ge_drogue;
	logic                 ge_ss_coast, ge_main, ge_landing, ge_staging;

	// one step per cycle whenever an item waits and the result queue has room
	assign item_pop    = !item_empty && !result_full;
	assign result_push = item_pop;

	// elapsed time in phase, wrapping
	assign now_t   = TIME_BITS'(item.now_ms);
	assign entry_t = entry_done_q ? entry_time_q : now_t;
	assign elapsed = now_t - entry_t;

	assign ge_short    = (elapsed >= TIME_BITS'(WAIT_SHORT));
	assign ge_burn     = (elapsed >= TIME_BITS'(WAIT_BURN));
	assign ge_startup  = (elapsed >= TIME_BITS'(WAIT_STARTUP));
	assign ge_ss_drop  = (elapsed >= TIME_BITS'(WAIT_SS_DROP));
	assign ge_drogue   = (elapsed >= TIME_BITS'(WAIT_DROGUE));
	assign ge_ss_coast = (elapsed >= TIME_BITS'(WAIT_SS_COAST));
	assign ge_main     = (elapsed >= TIME_BITS'(WAIT_MAIN));
	assign ge_landing  = (elapsed >= TIME_BITS'(WAIT_LANDING));
	assign ge_staging  = (elapsed >= TIME_BITS'(staging_delay));

	// operation decode, phase checks and pyro pulses
	always_comb begin
		phase_n      = phase_q;
		armed_n      = armed_q;
		entry_done_n = entry_done_q;
		entry_time_n = entry_time_q;
		next_phase   = phase_q;
		result       = '0;
		unique case (item.op)
			OP_ARM:    armed_n = 1'b1;
			OP_DISARM: armed_n = 1'b0;
			OP_FORCE:  phase_n = item.forced_phase;
			OP_DETECT: begin
				if (!armed_q) begin
					phase_n                  = PH_STARTUP;
					result.calibrate_request = CAL_DISARMED;
				end else if (phase_q > PH_LANDING) begin
					armed_n          = 1'b0;
					result.bad_phase = 1'b1;
				end else begin
					entry_done_n          = 1'b1;
					entry_time_n          = entry_t;
					result.in_flight_mark = !entry_done_q && (phase_q == PH_BOOST);
					unique case (phase_q)
						PH_STARTUP: begin
							result.calibrate_request = CAL_STARTUP;
							if (ge_startup) next_phase = PH_PREFLIGHT;
						end
						PH_PREFLIGHT: begin
							result.calibrate_request = CAL_PREFLIGHT;
							if (ge_short && item.burn) next_phase = PH_BOOST;
						end
						PH_BOOST: begin
							if (ge_burn && item.burnout) next_phase = PH_SS_DELAY;
						end
						PH_SS_DELAY: begin
							if (ge_staging) begin
								result.fire_second_stage = 1'b1;
								next_phase               = PH_SS_IGNITE;
							end
							if (ge_burn && item.drop) next_phase = PH_FREE_FALL;
						end
						PH_SS_IGNITE: begin
							if (ge_short && item.burn) next_phase = PH_SS_BOOST;
							if (ge_ss_coast) next_phase = PH_COAST;
							if (ge_ss_drop && item.drop) next_phase = PH_FREE_FALL;
						end
						PH_SS_BOOST: begin
							if (ge_burn && item.burnout) next_phase = PH_COAST;
						end
						PH_COAST: begin
							if (ge_burn && item.drop) next_phase = PH_FREE_FALL;
						end
						PH_FREE_FALL: begin
							result.fire_apogee = 1'b1;
							next_phase         = PH_DROGUE;
						end
						PH_DROGUE: begin
							if (ge_short && item.main_ok) begin
								result.fire_main = 1'b1;
								next_phase       = PH_MAIN;
							end else if (ge_drogue && item.fast) begin
								next_phase = PH_DROGUE_NG;
							end
						end
						PH_DROGUE_NG: begin
							if (ge_short) begin
								result.fire_apogee = 1'b1;
								result.fire_main   = 1'b1;
								next_phase         = PH_MAIN;
							end
						end
						PH_MAIN: begin
							if (ge_main && item.fast) next_phase = PH_RECOV_NG;
							else if (ge_landing && item.landed) next_phase = PH_LANDING;
						end
						PH_RECOV_NG: begin
							if (ge_landing && item.landed) next_phase = PH_LANDING;
						end
						PH_LANDING: begin
							if (ge_landing) next_phase = PH_SHUTDOWN;
						end
						default: next_phase = phase_q;
					endcase
					// a new phase restarts its entry timing
					if (next_phase != phase_q) begin
						phase_n      = next_phase;
						entry_done_n = 1'b0;
					end else if (phase_q == PH_FREE_FALL) begin
						entry_done_n = 1'b0;
					end
				end
			end
			default: ;
		endcase
		result.phase    = phase_n;
		result.is_armed = armed_n;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STARTUP;
			armed_q      <= 1'b0;
			entry_done_q <= 1'b0;
			entry_time_q <= '0;
		end else if (item_pop) begin
			phase_q      <= phase_n;
			armed_q      <= armed_n;
			entry_done_q <= entry_done_n;
			entry_time_q <= entry_time_n;
		end
	end

endmodule
